### rtl/core/baro_altitude_vario_core_defines.svh
// Assertion macros for the barometric altitude and vario core.
// Included by files that check their own logic; needs clk_i and rst_ni in scope.
`ifndef BARO_ALTITUDE_VARIO_CORE_DEFINES_SVH
`define BARO_ALTITUDE_VARIO_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define BAV_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");
`define BAV_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define BAV_ASSERT(lbl, prop)
`define BAV_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### rtl/core/bav_pkg.sv
// Shared constants, types and the log2 table for the altitude and vario core.
// No dependencies.
package bav_pkg;

  localparam int LOG_TABLE_BITS = 6;
  localparam int TAB_SIZE = (1 << LOG_TABLE_BITS) + 1;
  localparam int REM_W = 30 - LOG_TABLE_BITS;
  localparam int LOG_W = 35;

  localparam int PRESS_W = 25;
  localparam int TIME_W = 32;
  localparam int ALPHA_W = 16;
  localparam int ALT_W = 31;
  localparam int VZ_W = 27;

  localparam int NUM_W = 41;
  localparam int DIV_STEPS = NUM_W;
  localparam int CNT_W = $clog2(DIV_STEPS);

  localparam logic [28:0] ALT_K = 29'd383146387;
  localparam logic signed [63:0] ALT_MIN = -64'sd131072000;
  localparam logic signed [63:0] ALT_MAX = 64'sd786432000;
  localparam logic [25:0] VZ_LIM = 26'd65536000;

  localparam logic [PRESS_W-1:0] REF_RESET = 25'd25939200;
  localparam logic [ALPHA_W-1:0] ALPHA_RESET = 16'd6554;

  typedef enum logic {
    REG_REF   = 1'b0,
    REG_ALPHA = 1'b1
  } reg_idx_e;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_LOGR, OP_LOGP, OP_ALT1, OP_ALT2, OP_SEED,
    OP_EMA1, OP_EMA2, OP_EMA3, OP_DIVI, OP_DIV, OP_FIN
  } op_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    logic first;
  } sts_t;

  typedef logic [30:0] log_tab_t [TAB_SIZE];

  // Point k holds log2(1 + k/2^LOG_TABLE_BITS) in Q.30, by repeated squaring.
  function automatic log_tab_t build_log_tab();
    log_tab_t    tab;
    logic [63:0] y;
    logic [30:0] r;
    for (int k = 0; k < TAB_SIZE - 1; k++) begin
      y = (64'd1 << 30) + (64'(k) << REM_W);
      r = '0;
      for (int i = 29; i >= 0; i--) begin
        y = (y * y) >> 30;
        if (y >= (64'd1 << 31)) begin
          y = y >> 1;
          r[i] = 1'b1;
        end
      end
      tab[k] = r;
    end
    tab[TAB_SIZE-1] = 31'd1 << 30;
    return tab;
  endfunction

  localparam log_tab_t LOG_TAB = build_log_tab();

  function automatic logic signed [63:0] sat(input logic signed [63:0] v,
                                             input logic signed [63:0] lo,
                                             input logic signed [63:0] hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

endpackage

### rtl/core/bav_if.sv
// Handshake channels of the altitude and vario core: sample in, result out.
// Depends on bav_pkg.
interface bav_in_if import bav_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [PRESS_W-1:0] pressure_q8;
  logic [TIME_W-1:0]  time_ms;
  modport source (output valid, pressure_q8, time_ms, input ready);
  modport sink (input valid, pressure_q8, time_ms, output ready);
endinterface

interface bav_out_if import bav_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [TIME_W-1:0]       stamp_ms;
  logic signed [ALT_W-1:0] altitude_q16;
  logic signed [VZ_W-1:0]  climb_rate_q16;
  modport source (output valid, stamp_ms, altitude_q16, climb_rate_q16, input ready);
  modport sink (input valid, stamp_ms, altitude_q16, climb_rate_q16, output ready);
endinterface

### rtl/core/bav_log2.sv
// Base-2 log of a 25-bit value in Q.30: leading one plus interpolated table.
// Depends on bav_pkg.
module bav_log2 import bav_pkg::*; (
  input  logic [PRESS_W-1:0] x_i,
  output logic [LOG_W-1:0]   log_o
);

  logic [PRESS_W-1:0]        xs;
  logic [4:0]                e;
  logic [PRESS_W+29:0]       mw;
  logic [29:0]               f;
  logic [LOG_TABLE_BITS-1:0] k;
  logic [LOG_TABLE_BITS:0]   k_hi;
  logic [REM_W-1:0]          rem;
  logic [30:0]               lo, hi, span;
  logic [30+REM_W:0]         prod;

  always_comb begin
    xs = (x_i == '0) ? PRESS_W'(1) : x_i;
    e = '0;
    for (int b = 0; b < PRESS_W; b++) begin
      if (xs[b]) e = 5'(b);
    end
    mw = {30'b0, xs} << (5'd30 - e);
    f = mw[29:0];
    k = f[29:REM_W];
    k_hi = {1'b0, k} + 1'b1;
    rem = f[REM_W-1:0];
    lo = LOG_TAB[k];
    hi = LOG_TAB[k_hi];
    span = hi - lo;
    prod = span * rem;
    log_o = {e, 30'b0} + LOG_W'(lo) + LOG_W'(prod[30+REM_W:REM_W]);
  end

endmodule

### rtl/core/bav_ctrl.sv
// Sequencer of the altitude and vario core: one operation a cycle unless stalled.
// Depends on bav_pkg.
module bav_ctrl import bav_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic out_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o,
  output logic in_ready_o,
  output logic out_valid_o
);

  typedef enum logic [11:0] {
    S_IDLE = 12'b000000000001,
    S_LOGR = 12'b000000000010,
    S_LOGP = 12'b000000000100,
    S_ALT1 = 12'b000000001000,
    S_ALT2 = 12'b000000010000,
    S_SEED = 12'b000000100000,
    S_EMA1 = 12'b000001000000,
    S_EMA2 = 12'b000010000000,
    S_EMA3 = 12'b000100000000,
    S_DIVI = 12'b001000000000,
    S_DIV  = 12'b010000000000,
    S_FIN  = 12'b100000000000
  } st_e;

  st_e              state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             ovld_q, ovld_d;

  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q;
    cmd_o.op = OP_NONE;
    ovld_d = ovld_q && !out_ready_i;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d = S_LOGR;
        end
      end
      S_LOGR: begin
        cmd_o.op = OP_LOGR;
        state_d = S_LOGP;
      end
      S_LOGP: begin
        cmd_o.op = OP_LOGP;
        state_d = S_ALT1;
      end
      S_ALT1: begin
        cmd_o.op = OP_ALT1;
        state_d = S_ALT2;
      end
      S_ALT2: begin
        cmd_o.op = OP_ALT2;
        state_d = sts_i.first ? S_SEED : S_EMA1;
      end
      S_SEED: begin
        cmd_o.op = OP_SEED;
        state_d = S_IDLE;
      end
      S_EMA1: begin
        cmd_o.op = OP_EMA1;
        state_d = S_EMA2;
      end
      S_EMA2: begin
        cmd_o.op = OP_EMA2;
        state_d = S_EMA3;
      end
      S_EMA3: begin
        cmd_o.op = OP_EMA3;
        state_d = S_DIVI;
      end
      S_DIVI: begin
        cmd_o.op = OP_DIVI;
        cnt_d = '0;
        state_d = S_DIV;
      end
      S_DIV: begin
        cmd_o.op = OP_DIV;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(DIV_STEPS - 1)) state_d = S_FIN;
      end
      S_FIN: begin
        if (!ovld_q || out_ready_i) begin
          cmd_o.op = OP_FIN;
          ovld_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign in_ready_o = (state_q == S_IDLE);
  assign out_valid_o = ovld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q <= '0;
      ovld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
      ovld_q <= ovld_d;
    end
  end

endmodule

### rtl/core/bav_dpath.sv
// Datapath of the altitude and vario core: log, scaling, smoothing, serial divider.
// Depends on bav_pkg and bav_log2.
module bav_dpath import bav_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  cmd_t                    cmd_i,
  input  logic [PRESS_W-1:0]      pressure_i,
  input  logic [TIME_W-1:0]       time_i,
  input  logic [PRESS_W-1:0]      ref_pressure_i,
  input  logic [ALPHA_W-1:0]      ema_alpha_i,
  output sts_t                    sts_o,
  output logic [TIME_W-1:0]       stamp_o,
  output logic signed [ALT_W-1:0] altitude_o,
  output logic signed [VZ_W-1:0]  climb_o
);

  logic [PRESS_W-1:0]      p_q;
  logic [TIME_W-1:0]       t_q;
  logic [LOG_W-1:0]        lr_q, lp_q, log_v;
  logic [56:0]             prod_q;
  logic                    neg_q, vneg_q;
  logic signed [31:0]      h_q, fnew_q, filt_q, prev_q;
  logic signed [49:0]      acc_q;
  logic [31:0]             dt_q, rem_q, ptime_q;
  logic [NUM_W-1:0]        nq_q;
  logic                    first_q;
  logic [TIME_W-1:0]       stamp_q;
  logic signed [ALT_W-1:0] alt_q;
  logic signed [VZ_W-1:0]  vz_q;

  logic signed [35:0]      d;
  logic signed [27:0]      d22;
  logic [27:0]             d22_mag;
  logic [57:0]             hsum;
  logic signed [36:0]      hs;
  logic [16:0]             wgt;
  logic signed [48:0]      m1, m2;
  logic [49:0]             amag;
  logic [50:0]             asum;
  logic signed [35:0]      es;
  logic [31:0]             dt_raw;
  logic signed [32:0]      diff;
  logic [31:0]             dmag;
  logic [32:0]             r2;
  logic                    qbit;
  logic [25:0]             vmag;

  bav_log2 u_log2 (
    .x_i   ((cmd_i.op == OP_LOGR) ? ref_pressure_i : p_q),
    .log_o (log_v)
  );

  always_comb begin
    d = $signed({1'b0, lr_q}) - $signed({1'b0, lp_q});
    d22 = d[35:8];
    d22_mag = d22[27] ? 28'(-d22) : 28'(d22);
    hsum = 58'(prod_q) + 58'(1 << 21);
    hs = neg_q ? -$signed({1'b0, hsum[57:22]}) : $signed({1'b0, hsum[57:22]});
    wgt = 17'h10000 - {1'b0, ema_alpha_i};
    m1 = h_q * $signed({1'b0, ema_alpha_i});
    m2 = filt_q * $signed({1'b0, wgt});
    amag = acc_q[49] ? 50'(-acc_q) : 50'(acc_q);
    asum = 51'(amag) + 51'd32768;
    es = acc_q[49] ? -$signed({1'b0, asum[50:16]}) : $signed({1'b0, asum[50:16]});
    dt_raw = t_q - ptime_q;
    diff = 33'(fnew_q) - 33'(prev_q);
    dmag = diff[32] ? 32'(-diff) : 32'(diff);
    r2 = {rem_q, nq_q[NUM_W-1]};
    qbit = (r2 >= {1'b0, dt_q});
    vmag = (nq_q > NUM_W'(VZ_LIM)) ? VZ_LIM : nq_q[25:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filt_q <= '0;
      prev_q <= '0;
      ptime_q <= '0;
      first_q <= 1'b1;
    end else begin
      if (cmd_i.op == OP_SEED) begin
        filt_q <= h_q;
        prev_q <= h_q;
        ptime_q <= t_q;
        first_q <= 1'b0;
      end else if (cmd_i.op == OP_FIN) begin
        filt_q <= fnew_q;
        prev_q <= fnew_q;
        ptime_q <= t_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        p_q <= pressure_i;
        t_q <= time_i;
      end
      OP_LOGR: lr_q <= log_v;
      OP_LOGP: lp_q <= log_v;
      OP_ALT1: begin
        prod_q <= d22_mag * ALT_K;
        neg_q <= d22[27];
      end
      OP_ALT2: h_q <= 32'(sat(64'(hs), ALT_MIN, ALT_MAX));
      OP_EMA1: acc_q <= 50'(m1);
      OP_EMA2: acc_q <= acc_q + 50'(m2);
      OP_EMA3: begin
        fnew_q <= 32'(sat(64'(es), ALT_MIN, ALT_MAX));
        dt_q <= (dt_raw == '0) ? 32'd1 : dt_raw;
      end
      OP_DIVI: begin
        nq_q <= NUM_W'(dmag) * NUM_W'(10'd1000) + NUM_W'(dt_q[31:1]);
        rem_q <= '0;
        vneg_q <= diff[32];
      end
      OP_DIV: begin
        rem_q <= qbit ? 32'(r2 - {1'b0, dt_q}) : r2[31:0];
        nq_q <= {nq_q[NUM_W-2:0], qbit};
      end
      OP_FIN: begin
        stamp_q <= t_q;
        alt_q <= fnew_q[ALT_W-1:0];
        vz_q <= vneg_q ? -$signed({1'b0, vmag}) : $signed({1'b0, vmag});
      end
      default: ;
    endcase
  end

  assign sts_o.first = first_q;
  assign stamp_o = stamp_q;
  assign altitude_o = alt_q;
  assign climb_o = vz_q;

endmodule

### rtl/core/baro_altitude_vario_core.sv
// Top level of the barometric altitude and vertical speed core.
// Depends on bav_pkg, bav_if, bav_ctrl, bav_dpath and the assertion macro header.
//
//   channel  | direction | carries
//   ---------+-----------+------------------------------------------------
//   in_i     | sink      | pressure_q8 (Q17.8 Pa), time_ms
//   out_o    | source    | stamp_ms, altitude_q16 (Q15.16), climb_rate_q16 (Q11.16)
//   APB      | slave     | ref_pressure at 0x0, ema_alpha at 0x4
//
// A result is valid once its item has passed the log, scaling, smoothing and
// division steps, and the next item can be taken only after that. The first item
// after reset only seeds the filter and frees the input again after its log and
// scaling steps. The serial divider of the vertical speed is the longest step:
// it retires one quotient bit a cycle over 41 bits.
// Reset clears the filter state, the registers to their defaults and the
// handshakes. A waiting result does not block the next item; that item stalls
// only in its last cycle until the previous result has been taken.

`include "baro_altitude_vario_core_defines.svh"

module baro_altitude_vario_core import bav_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  bav_in_if.sink            in_i,
  bav_out_if.source         out_o,
  input  logic              psel_i,
  input  logic              penable_i,
  input  logic              pwrite_i,
  input  logic [2:0]        paddr_i,
  input  logic [31:0]       pwdata_i,
  output logic [31:0]       prdata_o,
  output logic              pready_o
);

  logic [PRESS_W-1:0] ref_q;
  logic [ALPHA_W-1:0] alpha_q;
  reg_idx_e           reg_idx;
  logic               cfg_wr;
  cmd_t               cmd;
  sts_t               sts;

  // Registers are decoded on the word address bit; software must write them only
  // while the block is idle (the block does not enforce this), so no shadowing is needed.
  assign reg_idx = reg_idx_e'(paddr_i[2]);
  assign cfg_wr = psel_i && penable_i && pwrite_i;
  assign pready_o = 1'b1;

  always_comb begin
    unique case (reg_idx)
      REG_REF:   prdata_o = 32'(ref_q);
      REG_ALPHA: prdata_o = 32'(alpha_q);
      default:   prdata_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_q <= REF_RESET;
      alpha_q <= ALPHA_RESET;
    end else if (cfg_wr) begin
      if (reg_idx == REG_REF) ref_q <= pwdata_i[PRESS_W-1:0];
      else alpha_q <= pwdata_i[ALPHA_W-1:0];
    end
  end

  // The sequencer walks through the log, scaling, smoothing and division steps.
  bav_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid)
  );

  // The datapath holds the filter state and the result register.
  bav_dpath u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .pressure_i     (in_i.pressure_q8),
    .time_i         (in_i.time_ms),
    .ref_pressure_i (ref_q),
    .ema_alpha_i    (alpha_q),
    .sts_o          (sts),
    .stamp_o        (out_o.stamp_ms),
    .altitude_o     (out_o.altitude_q16),
    .climb_o        (out_o.climb_rate_q16)
  );

  `BAV_ASSERT_NEXT(a_busy_after_accept, in_i.valid && in_i.ready, !in_i.ready)
  `BAV_ASSERT(a_vz_range, out_o.valid |-> (out_o.climb_rate_q16 <= 27'sd65536000) && (out_o.climb_rate_q16 >= -27'sd65536000))
  `BAV_ASSERT(a_alt_range, out_o.valid |-> (out_o.altitude_q16 <= 31'sd786432000) && (out_o.altitude_q16 >= -31'sd131072000))

endmodule

### sim/tb_top.sv
// Testbench for the barometric altitude and vertical speed core.
// Depends on bav_pkg, bav_if and the core; checks every result against its own predictor or a typed row.
module tb_top;
  import bav_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 20000;
  // Drain margin: covers a seeding item or any other item still in flight.
  localparam int DRAIN_CYCLES = 70;
  localparam int HOLD_CYCLES = 600;
  localparam int RANDOM_ITEMS = 1700;

  typedef struct packed {
    logic [TIME_W-1:0]       stamp;
    logic signed [ALT_W-1:0] alt;
    logic signed [VZ_W-1:0]  climb;
  } vario_res_t;

  // Row of the directed table; a typed row carries its expected result by hand.
  typedef struct packed {
    logic [PRESS_W-1:0]      press;
    logic [TIME_W-1:0]       stamp;
    bit                      typed;
    logic signed [ALT_W-1:0] alt;
    logic signed [VZ_W-1:0]  climb;
  } sample_row_t;

  logic clk_i;
  logic rst_ni;
  logic psel_i, penable_i, pwrite_i;
  logic [2:0] paddr_i;
  logic [31:0] pwdata_i;
  logic [31:0] prdata_o;
  logic pready_o;

  bav_in_if  sample_if ();
  bav_out_if vario_if ();

  baro_altitude_vario_core u_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (sample_if.sink),
    .out_o     (vario_if.source),
    .psel_i    (psel_i),
    .penable_i (penable_i),
    .pwrite_i  (pwrite_i),
    .paddr_i   (paddr_i),
    .pwdata_i  (pwdata_i),
    .prdata_o  (prdata_o),
    .pready_o  (pready_o)
  );

  // Predictor state: configuration plus the filter and timebase of the block.
  longint unsigned   log2_pts [TAB_SIZE];
  logic [PRESS_W-1:0] ref_press_q;
  logic [ALPHA_W-1:0] alpha_q;
  longint            filt_alt_q, prev_alt_q;
  logic [TIME_W-1:0] prev_stamp_q;
  bit                seeding_q;

  vario_res_t expected_q [$];
  int  err_cnt;
  int  items_sent;
  bit  activity;
  bit  holdoff_done;
  int  holdoff_left;
  int  burst_left;

  // Clock with a 10 ns period.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Points of log2(1 + k/64) in Q.30, computed by repeated squaring, truncating.
  initial begin
    longint unsigned y, r;
    for (int k = 0; k < TAB_SIZE - 1; k++) begin
      y = (64'd1 << 30) + (64'(k) << REM_W);
      r = 0;
      for (int i = 29; i >= 0; i--) begin
        y = (y * y) >> 30;
        if (y >= (64'd1 << 31)) begin
          y = y >> 1;
          r |= 64'd1 << i;
        end
      end
      log2_pts[k] = r;
    end
    log2_pts[TAB_SIZE-1] = 64'd1 << 30;
  end

  // log2 of a pressure in Q.30: leading-one position plus interpolated fraction.
  function automatic longint log2_q30(logic [PRESS_W-1:0] x);
    int e;
    longint unsigned m, f, rem, lo, hi;
    int k;
    if (x == 0) x = 1;
    e = 24;
    while (e > 0 && !x[e]) e--;
    m = 64'(x) << (30 - e);
    f = m - (64'd1 << 30);
    k = int'(f >> REM_W);
    rem = f & ((64'd1 << REM_W) - 1);
    lo = log2_pts[k];
    hi = log2_pts[k+1];
    return (longint'(e) << 30) + longint'(lo + (((hi - lo) * rem) >> REM_W));
  endfunction

  // Signed division by a positive divisor, rounded half away from zero.
  function automatic longint div_half_away(longint v, longint unsigned d);
    longint unsigned mag, q;
    mag = (v < 0) ? longint'(-v) : v;
    q = (mag + d / 2) / d;
    return (v < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Advances the predicted filter by one sample; returns 1 when a result is due.
  function automatic bit predict_vario(logic [PRESS_W-1:0] press, logic [TIME_W-1:0] stamp,
                                       output vario_res_t res);
    longint d, d22, h, filt, climb;
    logic [TIME_W-1:0] dt;
    d = log2_q30(ref_press_q) - log2_q30(press);
    d22 = d >>> 8;  // floor to Q.22
    h = div_half_away(d22 * 64'sd383146387, 64'd1 << 22);
    h = clip(h, ALT_MIN, ALT_MAX);
    res = '0;
    if (seeding_q) begin
      filt_alt_q = h;
      prev_alt_q = h;
      prev_stamp_q = stamp;
      seeding_q = 1'b0;
      return 1'b0;
    end
    filt = div_half_away(h * longint'(alpha_q) + filt_alt_q * (65536 - longint'(alpha_q)),
                         65536);
    filt = clip(filt, ALT_MIN, ALT_MAX);
    filt_alt_q = filt;
    dt = stamp - prev_stamp_q;
    if (dt == 0) dt = 1;
    climb = div_half_away((filt - prev_alt_q) * 1000, 64'(dt));
    climb = clip(climb, -64'sd65536000, 64'sd65536000);
    res.stamp = stamp;
    res.alt = filt[ALT_W-1:0];
    res.climb = climb[VZ_W-1:0];
    prev_alt_q = filt;
    prev_stamp_q = stamp;
    return 1'b1;
  endfunction

  // Offers one sample and waits for it to be taken. Valid stays high within a
  // burst, so back-to-back items see no bubble; a gap follows each burst.
  task automatic send_sample(logic [PRESS_W-1:0] press, logic [TIME_W-1:0] stamp,
                             bit typed = 1'b0, vario_res_t typed_res = '0);
    vario_res_t res;
    sample_if.valid <= 1'b1;
    sample_if.pressure_q8 <= press;
    sample_if.time_ms <= stamp;
    @(posedge clk_i);
    while (!sample_if.ready) @(posedge clk_i);
    if (predict_vario(press, stamp, res)) begin
      if (typed) res = typed_res;
      expected_q.push_back(res);
    end
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 9) == 0 ? $urandom_range(20, 60) : $urandom_range(0, 7);
      sample_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  // Register write: setup cycle, then access cycle; pready is always high.
  // The task returns with the bus idle.
  task automatic write_reg(reg_idx_e idx, logic [31:0] value);
    psel_i <= 1'b1;
    penable_i <= 1'b0;
    pwrite_i <= 1'b1;
    paddr_i <= {idx, 2'b00};
    pwdata_i <= value;
    @(posedge clk_i);
    penable_i <= 1'b1;
    @(posedge clk_i);
    while (!pready_o) @(posedge clk_i);
    psel_i <= 1'b0;
    penable_i <= 1'b0;
    pwrite_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      REG_REF:   ref_press_q = value[PRESS_W-1:0];
      REG_ALPHA: alpha_q = value[ALPHA_W-1:0];
      default: ;
    endcase
  endtask

  // Lets every expected result arrive, then covers a seeding item still in flight.
  task automatic drain;
    sample_if.valid <= 1'b0;
    @(posedge clk_i);
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Result side: ready while items_sent mod 256 is below 64, else random stalls;
  // one long hold-off after 400 items are sent fills the block and stalls its input.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vario_if.ready <= 1'b0;
      holdoff_left <= 0;
      holdoff_done <= 1'b0;
    end else if (holdoff_left > 0) begin
      vario_if.ready <= 1'b0;
      holdoff_left <= holdoff_left - 1;
    end else if (!holdoff_done && items_sent >= 400) begin
      vario_if.ready <= 1'b0;
      holdoff_left <= HOLD_CYCLES;
      holdoff_done <= 1'b1;
    end else if (items_sent % 256 < 64) begin
      vario_if.ready <= 1'b1;
    end else begin
      vario_if.ready <= ($urandom_range(0, 3) != 0);
    end
  end

  // Result checker: compares each accepted result with the oldest expectation.
  always @(posedge clk_i) begin
    vario_res_t want;
    if (rst_ni && vario_if.valid && vario_if.ready) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result: stamp_ms %0d", vario_if.stamp_ms);
        err_cnt++;
      end else begin
        want = expected_q.pop_front();
        if (vario_if.stamp_ms !== want.stamp) begin
          $error("stamp_ms: expected %0d, actual %0d", want.stamp, vario_if.stamp_ms);
          err_cnt++;
        end
        if (vario_if.altitude_q16 !== want.alt) begin
          $error("altitude_q16: expected %0d, actual %0d", want.alt, vario_if.altitude_q16);
          err_cnt++;
        end
        if (vario_if.climb_rate_q16 !== want.climb) begin
          $error("climb_rate_q16: expected %0d, actual %0d", want.climb,
                 vario_if.climb_rate_q16);
          err_cnt++;
        end
      end
    end
  end

  // Watchdog: ends the run when nothing moves for too long.
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if ((sample_if.valid && sample_if.ready) || (vario_if.valid && vario_if.ready) ||
          (psel_i && penable_i)) quiet = 0;
      else quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("FAIL baro_altitude_vario_core");
        $finish;
      end
    end
  end

  // Directed samples at the reset settings. The first seeds the filter; the
  // second at reference pressure must give zero altitude and zero speed.
  // Then zero pressure (saturates high), all ones (saturates low), range ends,
  // a repeated timestamp, a wrap of the millisecond counter and two bit patterns.
  sample_row_t sample_rows [] = '{
    '{25'd25939200, 32'd1000,       1'b1, 31'sd0, 27'sd0},
    '{25'd25939200, 32'd1050,       1'b1, 31'sd0, 27'sd0},
    '{25'd0,        32'd1100,       1'b0, 31'sd0, 27'sd0},
    '{25'h1FFFFFF,  32'd1150,       1'b0, 31'sd0, 27'sd0},
    '{25'd7680000,  32'd1200,       1'b0, 31'sd0, 27'sd0},
    '{25'd28160000, 32'd1200,       1'b0, 31'sd0, 27'sd0},
    '{25'd20000000, 32'hFFFFFFF0,   1'b0, 31'sd0, 27'sd0},
    '{25'd20000500, 32'd5,          1'b0, 31'sd0, 27'sd0},
    '{25'h0AAAAAA,  32'hAAAAAAAA,   1'b0, 31'sd0, 27'sd0},
    '{25'h1555555,  32'h55555555,   1'b0, 31'sd0, 27'sd0}
  };

  // Samples driven under extreme settings: fast jumps make the speed saturate.
  sample_row_t jump_rows [] = '{
    '{25'd0,        32'd2000,       1'b0, 31'sd0, 27'sd0},
    '{25'h1FFFFFF,  32'd2001,       1'b0, 31'sd0, 27'sd0},
    '{25'd7680000,  32'd2001,       1'b0, 31'sd0, 27'sd0},
    '{25'd28160000, 32'd2500,       1'b0, 31'sd0, 27'sd0},
    '{25'd12345678, 32'd3000,       1'b0, 31'sd0, 27'sd0}
  };

  task automatic play_rows(sample_row_t rows []);
    vario_res_t tr;
    foreach (rows[i]) begin
      tr.stamp = rows[i].stamp;
      tr.alt = rows[i].alt;
      tr.climb = rows[i].climb;
      send_sample(rows[i].press, rows[i].stamp, rows[i].typed, tr);
    end
  endtask

  // Main sequence: reset, directed part, register extremes, random part, end.
  initial begin
    logic [PRESS_W-1:0] press;
    logic [TIME_W-1:0]  stamp;
    longint             p_walk;
    int                 pick;
    rst_ni = 1'b0;
    psel_i = 1'b0;
    penable_i = 1'b0;
    pwrite_i = 1'b0;
    paddr_i = '0;
    pwdata_i = '0;
    sample_if.valid = 1'b0;
    sample_if.pressure_q8 = '0;
    sample_if.time_ms = '0;
    err_cnt = 0;
    items_sent = 0;
    burst_left = 0;
    ref_press_q = REF_RESET;
    alpha_q = ALPHA_RESET;
    filt_alt_q = 0;
    prev_alt_q = 0;
    prev_stamp_q = '0;
    seeding_q = 1'b1;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    play_rows(sample_rows);

    // Extremes of both registers, including a zero reference pressure.
    drain();
    write_reg(REG_ALPHA, 32'hFFFFFFFF);
    write_reg(REG_REF, 32'd28160000);
    play_rows(jump_rows);
    drain();
    write_reg(REG_REF, 32'd0);
    write_reg(REG_ALPHA, 32'd0);
    play_rows(jump_rows);
    drain();
    write_reg(REG_REF, 32'h01FFFFFF);
    write_reg(REG_ALPHA, 32'd32768);
    play_rows(jump_rows);
    drain();
    write_reg(REG_REF, 32'd7680000);
    write_reg(REG_ALPHA, 32'd65535);
    play_rows(jump_rows);
    drain();
    write_reg(REG_REF, 32'(REF_RESET));
    write_reg(REG_ALPHA, 32'(ALPHA_RESET));

    // Random part: mostly a realistic pressure walk at sensor rate, with
    // full-range pressures, repeated stamps and timer jumps mixed in.
    p_walk = 25939200;
    stamp = prev_stamp_q;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 300 == 299) begin
        drain();
        write_reg(REG_REF, $urandom_range(0, 9) == 0 ? $urandom : $urandom_range(7680000, 28160000));
        write_reg(REG_ALPHA, $urandom_range(0, 7) == 0 ? $urandom : $urandom_range(1000, 20000));
      end
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        p_walk = clip(p_walk + $urandom_range(0, 20000) - 10000, 7680000, 28160000);
        press = p_walk[PRESS_W-1:0];
        stamp = stamp + $urandom_range(10, 120);
      end else if (pick < 86) begin
        press = p_walk[PRESS_W-1:0];
      end else if (pick < 94) begin
        press = $urandom_range(0, (1 << PRESS_W) - 1);
        stamp = stamp + $urandom_range(1, 5);
      end else begin
        press = $urandom_range(7680000, 28160000);
        stamp = $urandom;
      end
      send_sample(press, stamp);
    end

    drain();
    if (err_cnt == 0) begin
      $display("PASS baro_altitude_vario_core");
    end else begin
      $display("FAIL baro_altitude_vario_core");
    end
    $finish;
  end

endmodule
